[design/round_robin_ready_queue_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin ready queue
// Shared assertion forms. Define NO_ASSERTIONS to leave them out.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_READY_QUEUE_TOP_DEFINES_SVH
`define ROUND_ROBIN_READY_QUEUE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge outside reset
`define RRQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included
`define RRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RRQ_ASSERT(lbl, clk, rst, prop, msg)
`define RRQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[design/rrq_pkg.sv]
// ----------------------------------------------------------------------------
// rrq_pkg
// Types and constants shared by the ready queue cells and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;

   // Item operation codes
   typedef enum logic [OP_BITS-1:0] {
      OP_READY     = 2'd0,
      OP_NOT_READY = 2'd1,
      OP_SCHEDULE  = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STAT_DONE      = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   // Per-cell command
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_LOAD,
      CELL_SCAN
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         in_window;
   } cell_ctrl_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

`default_nettype wire

[design/rrq_cell.sv]
// ----------------------------------------------------------------------------
// rrq_cell
// One queue slot. Holds, shifts in from its right neighbour, loads a new id,
// or takes part in a removal scan that passes a hit carry along the row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrq_cell import rrq_pkg::*; (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [ID_BITS-1:0]  load_data,
   input  logic [ID_BITS-1:0]  key,
   input  logic [ID_BITS-1:0]  right_entry,
   input  logic                carry_in,
   output logic                carry_out,
   output logic [ID_BITS-1:0]  entry
);

   logic [ID_BITS-1:0] entry_ff;
   logic [ID_BITS-1:0] entry_in;
   logic               hit;

   // Hit carry: set from the first live match at or to the left of this cell
   always_comb begin
      hit       = (ctrl.cmd == CELL_SCAN) && ctrl.in_window && (entry_ff == key);
      carry_out = carry_in | hit;
   end

   // Slot update
   always_comb begin
      case (ctrl.cmd)
         CELL_SHIFT: entry_in = right_entry;
         CELL_LOAD:  entry_in = load_data;
         CELL_SCAN:  entry_in = carry_out ? right_entry : entry_ff;
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

[design/round_robin_ready_queue_top.sv]
// ----------------------------------------------------------------------------
// round_robin_ready_queue_top
// Round-robin thread scheduler: FIFO ready queue in a row of cells plus a
// running-thread register.
// ----------------------------------------------------------------------------
// Timing: ready, schedule, no-op and a not-ready that hits the head (or finds
// the queue empty) complete in the accept cycle and their result is
// registered for the next cycle. A not-ready that misses the head starts a
// scan of the cell row that removes one matching entry per cycle, then
// confirms that no match is left before its result is registered; the
// confirmation waits while the output register is blocked. The request side
// is stalled while a scan runs, while an undelivered result blocks the output
// register or while a configuration write is offered.
// A configuration write sets the running thread and empties the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "round_robin_ready_queue_top_defines.svh"

module round_robin_ready_queue_top import rrq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_BITS-1:0]     req_operation,
   input  logic [ID_BITS-1:0]     req_thread_id,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic                   rsp_switched,
   output logic [ID_BITS-1:0]     rsp_running_thread,
   output logic [CNT_BITS-1:0]    rsp_queue_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ID_BITS-1:0]     csr_initial_thread_id
);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [ID_BITS-1:0]  running_ff, running_in;
   logic [ID_BITS-1:0]  key_ff, key_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic                rsp_switched_ff;
   logic [ID_BITS-1:0]  rsp_running_ff;
   logic [CNT_BITS-1:0] rsp_count_ff;

   status_type          status_new;
   logic                switched_new;
   logic                rsp_load;
   logic                rsp_free;
   logic                req_accept;
   logic                csr_write;
   logic                scan_start;
   logic                scan_hit;
   op_type              op;
   logic [ID_BITS-1:0]  load_data;

   cell_cmd_type        cell_cmd    [QUEUE_DEPTH];
   logic                cell_window [QUEUE_DEPTH];
   cell_ctrl_type       cell_ctrl   [QUEUE_DEPTH];
   logic [ID_BITS-1:0]  entry       [QUEUE_DEPTH];
   logic                carry       [QUEUE_DEPTH+1];

   // Handshakes; a configuration write takes priority over a request
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !rsp_free || csr_valid;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_write  = csr_valid && csr_ready;
   assign op         = op_type'(req_operation);

   // A not-ready that misses the head needs the scan
   assign scan_start = req_accept && (op == OP_NOT_READY) &&
                       (count_ff != '0) && (entry[0] != req_thread_id);

   // New ids come from the request, except on a schedule tick
   assign load_data = (op == OP_SCHEDULE) ? running_ff : req_thread_id;

   // Cell row
   assign carry[0] = 1'b0;
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [ID_BITS-1:0] right_entry;

      assign cell_window[i] = (i != 0) && (CNT_BITS'(i) < count_ff);
      assign cell_ctrl[i]   = '{cmd: cell_cmd[i], in_window: cell_window[i]};

      if (i == QUEUE_DEPTH - 1) begin : g_end
         assign right_entry = '0;
      end else begin : g_mid
         assign right_entry = entry[i+1];
      end

      rrq_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .load_data   (load_data),
         .key         (key_ff),
         .right_entry (right_entry),
         .carry_in    (carry[i]),
         .carry_out   (carry[i+1]),
         .entry       (entry[i])
      );
   end

   assign scan_hit = carry[QUEUE_DEPTH];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (scan_start) state_in = ST_SCAN;
         ST_SCAN: if (!scan_hit && rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath control and result
   always_comb begin
      count_in     = count_ff;
      running_in   = running_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      rsp_load     = 1'b0;
      status_new   = STAT_DONE;
      switched_new = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_cmd[i] = CELL_HOLD;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_write) begin
               count_in   = '0;
               running_in = csr_initial_thread_id;
            end else if (req_accept) begin
               rsp_load = 1'b1;
               case (op)
                  OP_READY: begin
                     if (count_ff >= CNT_BITS'(QUEUE_DEPTH)) begin
                        status_new = STAT_FULL;
                     end else begin
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                           if (CNT_BITS'(i) == count_ff) cell_cmd[i] = CELL_LOAD;
                        end
                        count_in = count_ff + CNT_BITS'(1);
                     end
                  end
                  OP_NOT_READY: begin
                     if (count_ff == '0) begin
                        status_new = STAT_NOT_FOUND;
                     end else if (entry[0] == req_thread_id) begin
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                           cell_cmd[i] = CELL_SHIFT;
                        end
                        count_in = count_ff - CNT_BITS'(1);
                     end else begin
                        // result comes at the end of the scan
                        rsp_load = 1'b0;
                        key_in   = req_thread_id;
                        found_in = 1'b0;
                     end
                  end
                  OP_SCHEDULE: begin
                     if (count_ff == '0) begin
                        status_new = STAT_EMPTY;
                     end else begin
                        // pop head, running thread goes to the tail
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                           cell_cmd[i] = (CNT_BITS'(i) == count_ff - CNT_BITS'(1)) ?
                                         CELL_LOAD : CELL_SHIFT;
                        end
                        running_in   = entry[0];
                        switched_new = 1'b1;
                     end
                  end
                  default: status_new = STAT_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            // one match removed per cycle, first match in the row wins
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               cell_cmd[i] = CELL_SCAN;
            end
            if (scan_hit) begin
               count_in = count_ff - CNT_BITS'(1);
               found_in = 1'b1;
            end else if (rsp_free) begin
               rsp_load   = 1'b1;
               status_new = found_ff ? STAT_DONE : STAT_NOT_FOUND;
            end
         end
         default: count_in = count_ff;
      endcase
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         running_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (rsp_load) begin
         rsp_status_ff   <= status_new;
         rsp_switched_ff <= switched_new;
         rsp_running_ff  <= running_in;
         rsp_count_ff    <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_switched       = rsp_switched_ff;
   assign rsp_running_thread = rsp_running_ff;
   assign rsp_queue_count    = rsp_count_ff;

   // Checks
   `RRQ_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CNT_BITS'(QUEUE_DEPTH)), "count")
   `RRQ_ASSERT(a_scan_stalls, clock, reset, (state_ff == ST_SCAN) |-> req_stall, "item taken during scan")
   `RRQ_ASSERT(a_scan_shrinks, clock, reset, (state_ff == ST_SCAN) |=> (count_ff <= $past(count_ff)), "scan grew queue")
   `RRQ_ASSERT(a_switch_done, clock, reset, (rsp_valid_ff && rsp_switched_ff) |-> (rsp_status_ff == STAT_DONE), "switch with bad status")

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin ready queue testbench
// Drives mark-ready, mark-not-ready, schedule and no-op items into the
// scheduler, predicts each result from a local model of the queue and the
// running thread, and compares every delivered result field by field. Both
// channels idle and stall at random. The initial thread register is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------

module testbench;
   import rrq_pkg::*;

   // Expected contents of one result item
   typedef struct packed {
      status_type            status;
      logic                  switched;
      logic [ID_BITS-1:0]    running;
      logic [CNT_BITS-1:0]   count;
   } sched_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   op_type                 req_operation = OP_NONE;
   logic [ID_BITS-1:0]     req_thread_id = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic                   rsp_switched;
   logic [ID_BITS-1:0]     rsp_running_thread;
   logic [CNT_BITS-1:0]    rsp_queue_count;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [ID_BITS-1:0]     csr_initial_thread_id = '0;

   // Scheduler state as predicted
   logic [ID_BITS-1:0]     pred_queue [QUEUE_DEPTH];
   int                     pred_count = 0;
   logic [ID_BITS-1:0]     pred_running = '0;

   sched_result_type       expected_results [$];
   int                     fail_count = 0;
   bit                     idling_on = 1'b1;
   int                     stall_left = 0;
   logic [ID_BITS-1:0]     id_pool [4];

   round_robin_ready_queue_top i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_thread_id         (req_thread_id),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_switched          (rsp_switched),
      .rsp_running_thread    (rsp_running_thread),
      .rsp_queue_count       (rsp_queue_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_initial_thread_id (csr_initial_thread_id)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (!idling_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Drop the head entry and close up the queue
   function automatic void pop_ready_head();
      for (int i = 1; i < pred_count; i++)
         pred_queue[i-1] = pred_queue[i];
      if (pred_count > 0)
         pred_count--;
   endfunction

   // Apply one item to the predicted state and return its result
   function automatic sched_result_type predict_schedule(input op_type op,
                                                         input logic [ID_BITS-1:0] id);
      sched_result_type   res;
      int                 wr;
      logic [ID_BITS-1:0] next_id;
      res.status   = STAT_DONE;
      res.switched = 1'b0;
      case (op)
         OP_READY: begin
            if (pred_count >= QUEUE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               pred_queue[pred_count] = id;
               pred_count++;
            end
         end
         OP_NOT_READY: begin
            if (pred_count == 0) begin
               res.status = STAT_NOT_FOUND;
            end else if (pred_queue[0] == id) begin
               // head match removes the head only
               pop_ready_head();
            end else begin
               // strip every match behind the head
               wr = 1;
               for (int rd = 1; rd < pred_count; rd++) begin
                  if (pred_queue[rd] != id) begin
                     pred_queue[wr] = pred_queue[rd];
                     wr++;
                  end
               end
               if (wr == pred_count)
                  res.status = STAT_NOT_FOUND;
               pred_count = wr;
            end
         end
         OP_SCHEDULE: begin
            if (pred_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               next_id = pred_queue[0];
               pop_ready_head();
               pred_queue[pred_count] = pred_running;
               pred_count++;
               pred_running = next_id;
               res.switched = 1'b1;
            end
         end
         default: ;
      endcase
      res.running = pred_running;
      res.count   = CNT_BITS'(pred_count);
      return res;
   endfunction

   // Send one item; returns at the edge after acceptance plus any gap
   task automatic send_item(input op_type op, input logic [ID_BITS-1:0] id);
      bit taken;
      int gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_thread_id <= id;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      expected_results.push_back(predict_schedule(op, id));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait for every outstanding result, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (QUEUE_DEPTH + 4) @(posedge clock);
   endtask

   // Write the initial thread register; the scheduler restarts from it
   task automatic write_initial_thread(input logic [ID_BITS-1:0] value);
      bit taken;
      csr_valid             <= 1'b1;
      csr_initial_thread_id <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid    <= 1'b0;
      pred_running = value;
      pred_count   = 0;
   endtask

   task automatic compare_field(input string field, input logic [ID_BITS-1:0] exp_val,
                                input logic [ID_BITS-1:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, field, exp_val, act_val);
         fail_count++;
      end
   endtask

   // Result checker: sampled mid-cycle, taken at the next rising edge
   always @(negedge clock) begin : result_check
      sched_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result item: status %0d running %0d count %0d",
                     $time, rsp_status, rsp_running_thread, rsp_queue_count);
            fail_count++;
         end else begin
            exp_res = expected_results.pop_front();
            compare_field("status", ID_BITS'(exp_res.status), ID_BITS'(rsp_status));
            compare_field("switched", ID_BITS'(exp_res.switched), ID_BITS'(rsp_switched));
            compare_field("running_thread", exp_res.running, rsp_running_thread);
            compare_field("queue_count", ID_BITS'(exp_res.count), ID_BITS'(rsp_queue_count));
         end
      end
   end

   // Random back-pressure on the result side
   always @(posedge clock) begin : rsp_backpressure
      int len;
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         len = pick_gap();
         rsp_stall <= (len > 0);
         stall_left = (len > 0) ? len - 1 : 0;
      end
   end

   // Empty queue: schedule, removal and the unused operation code
   task automatic test_empty_queue_cases();
      send_item(OP_SCHEDULE, 8'h00);
      send_item(OP_NOT_READY, 8'hFF);
      send_item(OP_NONE, 8'h00);
   endtask

   // Head removal, removal of several matches, misses and switching
   task automatic test_removal_and_switch();
      send_item(OP_READY, 8'h00);
      send_item(OP_READY, 8'hFF);
      send_item(OP_READY, 8'h5A);
      send_item(OP_READY, 8'hFF);
      send_item(OP_READY, 8'h5A);
      send_item(OP_NOT_READY, 8'h00);
      send_item(OP_NOT_READY, 8'h33);
      send_item(OP_NOT_READY, 8'h5A);
      send_item(OP_NOT_READY, 8'hFF);
      send_item(OP_SCHEDULE, 8'h00);
      send_item(OP_SCHEDULE, 8'hFF);
      send_item(OP_NOT_READY, 8'hFF);
      // switch to the thread that is already running
      send_item(OP_READY, pred_running);
      send_item(OP_SCHEDULE, 8'h00);
   endtask

   // Fill to the limit, overflow, then schedule and remove while full
   task automatic test_full_queue();
      drain_results();
      write_initial_thread(8'hC3);
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_item(OP_READY, ID_BITS'(i * 17));
      send_item(OP_READY, 8'h80);
      send_item(OP_SCHEDULE, 8'h00);
      send_item(OP_NOT_READY, 8'h44);
   endtask

   // Random traffic in phases with different initial threads and mixes
   task automatic test_random_traffic();
      logic [ID_BITS-1:0] cfg_values [5];
      int                 ready_weight [5];
      int                 remove_weight [5];
      int                 r;
      op_type             op;
      logic [ID_BITS-1:0] id;
      cfg_values    = '{8'h00, 8'hFF, ID_BITS'($urandom), ID_BITS'($urandom), 8'h01};
      ready_weight  = '{45, 70, 35, 55, 45};
      remove_weight = '{25, 10, 40, 20, 25};
      for (int phase = 0; phase < 5; phase++) begin
         drain_results();
         write_initial_thread(cfg_values[phase]);
         // one phase runs without any idling
         idling_on = (phase != 2);
         foreach (id_pool[k])
            id_pool[k] = ID_BITS'($urandom);
         id_pool[0] = cfg_values[phase];
         for (int n = 0; n < 90; n++) begin
            r = $urandom_range(0, 99);
            if (r < ready_weight[phase])
               op = OP_READY;
            else if (r < ready_weight[phase] + remove_weight[phase])
               op = OP_NOT_READY;
            else if (r < 97)
               op = OP_SCHEDULE;
            else
               op = OP_NONE;
            // mostly a small set of threads so removals hit
            if ($urandom_range(0, 9) < 8)
               id = id_pool[$urandom_range(0, 3)];
            else
               id = ID_BITS'($urandom);
            send_item(op, id);
         end
      end
      idling_on = 1'b1;
   endtask

   // Main sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue_cases();
      test_removal_and_switch();
      test_full_queue();
      test_random_traffic();
      drain_results();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
